>>> rtl/core/sac_pkg.sv
// Shared types and constants for the set-associative cache hit/miss block.
// No dependencies; used by every module under rtl/core.
package sac_pkg;

    localparam int ADDR_W       = 16;
    localparam int MAX_SET_BITS = 4;
    localparam int MAX_WAY_BITS = 3;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int WAY_W        = MAX_WAY_BITS;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int NUM_WAYS     = 1 << MAX_WAY_BITS;
    localparam int TAG_W        = 16;
    localparam int RANK_W       = 3;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 5;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDR_BITS   = 3'd0,
        CFG_SET_BITS    = 3'd1,
        CFG_WAY_BITS    = 3'd2,
        CFG_OFFSET_BITS = 3'd3,
        CFG_POLICY      = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        POL_LRU  = 1'b0,
        POL_FIFO = 1'b1
    } t_policy;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } t_state;

    // effective (clamped) configuration
    typedef struct packed {
        logic [4:0] addr_bits;
        logic [2:0] set_bits;
        logic [1:0] way_bits;
        logic [3:0] offset_bits;
        t_policy    policy;
    } t_cfg;

    typedef struct packed {
        logic [NUM_WAYS-1:0][TAG_W-1:0]  tags;
        logic [NUM_WAYS-1:0][RANK_W-1:0] ranks;
    } t_row;

    typedef struct packed {
        logic                hit;
        logic [WAY_W-1:0]    way;
        logic [NUM_WAYS-1:0] valid;
        t_row                row;
    } t_upd;

endpackage

>>> rtl/core/sac_cfg_regs.sv
// Configuration registers of the cache block, with clamping of out-of-range values.
// Depends on sac_pkg.
module sac_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sac_pkg::t_cfg                  o_cfg
);

    logic [4:0]       r_addr_bits;
    logic [2:0]       r_set_bits;
    logic [1:0]       r_way_bits;
    logic [3:0]       r_offset_bits;
    sac_pkg::t_policy r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_bits   <= 5'd16;
            r_set_bits    <= 3'd2;
            r_way_bits    <= 2'd1;
            r_offset_bits <= 4'd4;
            r_policy      <= sac_pkg::POL_LRU;
        end else if (i_cfg_we) begin
            case (sac_pkg::t_cfg_idx'(i_cfg_index))
                sac_pkg::CFG_ADDR_BITS:   r_addr_bits   <= i_cfg_data[4:0];
                sac_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_data[2:0];
                sac_pkg::CFG_WAY_BITS:    r_way_bits    <= i_cfg_data[1:0];
                sac_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[3:0];
                sac_pkg::CFG_POLICY:      r_policy      <= sac_pkg::t_policy'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.addr_bits   = (r_addr_bits > 5'(sac_pkg::ADDR_W)) ?
                            5'(sac_pkg::ADDR_W) : r_addr_bits;
        o_cfg.set_bits    = (r_set_bits > 3'(sac_pkg::MAX_SET_BITS)) ?
                            3'(sac_pkg::MAX_SET_BITS) : r_set_bits;
        o_cfg.way_bits    = r_way_bits;
        o_cfg.offset_bits = r_offset_bits;
        o_cfg.policy      = r_policy;
    end

endmodule

>>> rtl/core/sac_set_ram.sv
// Set memory: one row per set holding the tags and order ranks of all ways.
// Synchronous, one write and one read port, registered read. Depends on sac_pkg.
module sac_set_ram (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [sac_pkg::SET_W-1:0]  i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [sac_pkg::SET_W-1:0]  i_wr_addr,
    input  sac_pkg::t_row              i_wr_data,
    output sac_pkg::t_row              o_rd_data
);

    sac_pkg::t_row mem [sac_pkg::NUM_SETS];
    sac_pkg::t_row r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/sac_lookup.sv
// Tag compare, way selection (hit, empty fill, victim) and rank update for one set row.
// Combinational; depends on sac_pkg.
module sac_lookup (
    input  sac_pkg::t_row                 i_row,
    input  logic [sac_pkg::NUM_WAYS-1:0]  i_valid,
    input  logic [sac_pkg::TAG_W-1:0]     i_tag,
    input  sac_pkg::t_cfg                 i_cfg,
    output sac_pkg::t_upd                 o_upd
);

    localparam int WAY_W  = sac_pkg::WAY_W;
    localparam int RANK_W = sac_pkg::RANK_W;

    logic [sac_pkg::NUM_WAYS-1:0] act_vec;
    logic [sac_pkg::NUM_WAYS-1:0] hit_vec;
    logic [sac_pkg::NUM_WAYS-1:0] empty_vec;
    logic [WAY_W-1:0]             hit_way;
    logic [WAY_W-1:0]             empty_way;
    logic [WAY_W-1:0]             best_way;
    logic [RANK_W-1:0]            best_rank;
    logic [WAY_W-1:0]             used;
    logic [RANK_W:0]              old_rank;
    logic                         touch;
    logic                         hit;
    logic                         empty;
    logic [WAY_W:0]               num_ways;

    always_comb begin
        num_ways = (WAY_W+1)'(1) << i_cfg.way_bits;
        for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
            act_vec[w]   = (WAY_W+1)'(w) < num_ways;
            hit_vec[w]   = act_vec[w] && i_valid[w] && (i_row.tags[w] == i_tag);
            empty_vec[w] = act_vec[w] && !i_valid[w];
        end

        hit_way   = '0;
        empty_way = '0;
        for (int w = sac_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (empty_vec[w]) begin
                empty_way = WAY_W'(w);
            end
        end

        // oldest way, lowest index on a tie
        best_way  = '0;
        best_rank = i_row.ranks[0];
        for (int w = 1; w < sac_pkg::NUM_WAYS; w++) begin
            if (act_vec[w] && (i_row.ranks[w] > best_rank)) begin
                best_way  = WAY_W'(w);
                best_rank = i_row.ranks[w];
            end
        end

        hit   = |hit_vec;
        empty = |empty_vec;

        if (hit) begin
            used     = hit_way;
            old_rank = {1'b0, i_row.ranks[hit_way]};
            touch    = (i_cfg.policy == sac_pkg::POL_LRU);
        end else if (empty) begin
            used     = empty_way;
            old_rank = (RANK_W+1)'(sac_pkg::NUM_WAYS);
            touch    = 1'b1;
        end else begin
            used     = best_way;
            old_rank = {1'b0, best_rank};
            touch    = 1'b1;
        end

        o_upd.hit   = hit;
        o_upd.way   = used;
        o_upd.valid = i_valid;
        o_upd.row   = i_row;
        if (!hit) begin
            o_upd.valid[used]    = 1'b1;
            o_upd.row.tags[used] = i_tag;
        end
        if (touch) begin
            for (int k = 0; k < sac_pkg::NUM_WAYS; k++) begin
                if (act_vec[k] && (WAY_W'(k) != used) && i_valid[k] &&
                    ({1'b0, i_row.ranks[k]} < old_rank) &&
                    (i_row.ranks[k] < sac_pkg::RANK_MAX)) begin
                    o_upd.row.ranks[k] = i_row.ranks[k] + RANK_W'(1);
                end
            end
            o_upd.row.ranks[used] = '0;
        end
    end

endmodule

>>> rtl/core/set_assoc_cache_hit_miss_top.sv
// Set-associative cache hit/miss tracker, LRU or FIFO replacement.
// Top level; depends on sac_pkg, sac_cfg_regs, sac_set_ram, sac_lookup.
//
// One address is taken at a clock edge where start is high and busy is low. Taking
// it reads the set's row (tags and ranks) from the set memory into a register; the
// lookup state then compares, picks the way and writes the row back; that
// read-modify-write of one memory row sets the rate, and busy interlocks the next
// read behind the write, so no new address is taken before the last one is done.
// The result is registered on the o_ ports together with the write and marked by
// o_result_valid, high for exactly one cycle; the receiver cannot stall it, so it must take every beat.
// o_hit_count and o_miss_count hold the saturating totals including that access.
// Valid bits live in flip-flops and clear at reset; there is no clearing pass.
module set_assoc_cache_hit_miss_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [sac_pkg::ADDR_W-1:0]     i_address,
    output logic                           o_result_valid,
    output logic                           o_hit,
    output logic [sac_pkg::SET_W-1:0]      o_set_index,
    output logic [sac_pkg::TAG_W-1:0]      o_tag_value,
    output logic [sac_pkg::WAY_W-1:0]      o_way_used,
    output logic [sac_pkg::CNT_W-1:0]      o_hit_count,
    output logic [sac_pkg::CNT_W-1:0]      o_miss_count
);

    localparam int ADDR_W = sac_pkg::ADDR_W;
    localparam int SET_W  = sac_pkg::SET_W;
    localparam int TAG_W  = sac_pkg::TAG_W;
    localparam int WAY_W  = sac_pkg::WAY_W;
    localparam int CNT_W  = sac_pkg::CNT_W;

    sac_pkg::t_cfg   cfg;
    sac_pkg::t_state r_state;
    sac_pkg::t_state n_state;
    sac_pkg::t_row   rd_row;
    sac_pkg::t_upd   upd;

    logic                   accept;
    logic                   do_update;
    logic [ADDR_W:0]        addr_mask;
    logic [ADDR_W-1:0]      addr_cut;
    logic [ADDR_W-1:0]      addr_shift;
    logic [SET_W:0]         set_mask;
    logic [4:0]             tag_shift;
    logic [SET_W-1:0]       in_set;
    logic [TAG_W-1:0]       in_tag;

    logic [SET_W-1:0]       r_set;
    logic [TAG_W-1:0]       r_tag;
    logic [sac_pkg::NUM_SETS-1:0][sac_pkg::NUM_WAYS-1:0] r_valid;
    logic [CNT_W-1:0]       r_hits;
    logic [CNT_W-1:0]       r_misses;
    logic [CNT_W-1:0]       n_hits;
    logic [CNT_W-1:0]       n_misses;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [SET_W-1:0]       r_out_set;
    logic [TAG_W-1:0]       r_out_tag;
    logic [WAY_W-1:0]       r_out_way;

    sac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // address split
    always_comb begin
        addr_mask  = ((ADDR_W+1)'(1) << cfg.addr_bits) - (ADDR_W+1)'(1);
        addr_cut   = i_address & addr_mask[ADDR_W-1:0];
        addr_shift = addr_cut >> cfg.offset_bits;
        set_mask   = ((SET_W+1)'(1) << cfg.set_bits) - (SET_W+1)'(1);
        in_set     = addr_shift[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift  = {1'b0, cfg.offset_bits} + {2'b0, cfg.set_bits};
        in_tag     = TAG_W'(addr_cut >> tag_shift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        accept    = 1'b0;
        do_update = 1'b0;
        busy      = 1'b0;
        case (r_state)
            sac_pkg::ST_IDLE: begin
                accept = start;
                if (start) begin
                    n_state = sac_pkg::ST_LOOKUP;
                end
            end
            sac_pkg::ST_LOOKUP: begin
                busy      = 1'b1;
                do_update = 1'b1;
                n_state   = sac_pkg::ST_IDLE;
            end
            default: n_state = sac_pkg::ST_IDLE;
        endcase
    end

    sac_set_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (in_set),
        .i_wr_en   (do_update),
        .i_wr_addr (r_set),
        .i_wr_data (upd.row),
        .o_rd_data (rd_row)
    );

    sac_lookup u_lookup (
        .i_row   (rd_row),
        .i_valid (r_valid[r_set]),
        .i_tag   (r_tag),
        .i_cfg   (cfg),
        .o_upd   (upd)
    );

    assign n_hits   = (upd.hit && (r_hits != '1)) ? r_hits + CNT_W'(1) : r_hits;
    assign n_misses = (!upd.hit && (r_misses != '1)) ? r_misses + CNT_W'(1) : r_misses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= do_update;
            if (do_update) begin
                r_valid[r_set] <= upd.valid;
                r_hits         <= n_hits;
                r_misses       <= n_misses;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= in_set;
            r_tag <= in_tag;
        end
        if (do_update) begin
            r_out_hit <= upd.hit;
            r_out_set <= r_set;
            r_out_tag <= r_tag;
            r_out_way <= upd.way;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_set_index    = r_out_set;
    assign o_tag_value    = r_out_tag;
    assign o_way_used     = r_out_way;
    assign o_hit_count    = r_hits;
    assign o_miss_count   = r_misses;

endmodule

>>> test/tb_set_assoc_cache_hit_miss_top.sv
// Testbench for set_assoc_cache_hit_miss_top: directed and random address streams under
// LRU and FIFO, checked beat by beat against a cycle-free cache predictor.
// Depends on sac_pkg and the RTL under rtl/core only.
module tb_set_assoc_cache_hit_miss_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;

    typedef struct {
        logic             hit;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } access_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  o_result_valid;
    logic                  o_hit;
    logic [SET_W-1:0]      o_set_index;
    logic [TAG_W-1:0]      o_tag_value;
    logic [WAY_W-1:0]      o_way_used;
    logic [CNT_W-1:0]      o_hit_count;
    logic [CNT_W-1:0]      o_miss_count;

    // cache predictor state
    t_cfg              cur_cfg = '{addr_bits: 5'd16, set_bits: 3'd2, way_bits: 2'd1,
                                   offset_bits: 4'd4, policy: POL_LRU};
    logic [TAG_W-1:0]  line_tag [NUM_SETS][NUM_WAYS];
    bit                line_valid [NUM_SETS][NUM_WAYS];
    bit [RANK_W-1:0]   line_age [NUM_SETS][NUM_WAYS];
    bit [CNT_W-1:0]    hits_so_far = '0;
    bit [CNT_W-1:0]    misses_so_far = '0;

    logic [ADDR_W-1:0] pending_addr_q[$];
    access_t           expected_access_q[$];
    int                items_queued = 0;
    int                beats_accepted = 0;
    int                mismatch_count = 0;
    int                sender_idle_pct = 0;

    set_assoc_cache_hit_miss_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_address      (i_address),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_set_index    (o_set_index),
        .o_tag_value    (o_tag_value),
        .o_way_used     (o_way_used),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // move way w to age 0, aging the valid ways that were younger than it
    function automatic void promote_way(int set_i, int nways, int w, int old_age);
        for (int k = 0; k < nways; k++) begin
            if (k != w && line_valid[set_i][k] && line_age[set_i][k] < old_age &&
                line_age[set_i][k] < RANK_MAX)
                line_age[set_i][k]++;
        end
        line_age[set_i][w] = '0;
    endfunction

    function automatic access_t cache_access(input logic [ADDR_W-1:0] addr_in);
        int          m;
        int          s;
        int          nways;
        int          set_i;
        int          used;
        logic [31:0] addr;
        logic [31:0] tag;
        bit          found;
        access_t     r;
        m = (cur_cfg.addr_bits > ADDR_W) ? ADDR_W : int'(cur_cfg.addr_bits);
        s = (cur_cfg.set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_cfg.set_bits);
        nways = 1 << ((cur_cfg.way_bits > MAX_WAY_BITS) ? MAX_WAY_BITS
                                                         : int'(cur_cfg.way_bits));
        addr = 32'(addr_in) & ((32'd1 << m) - 32'd1);
        set_i = int'((addr >> cur_cfg.offset_bits) & ((32'd1 << s) - 32'd1));
        tag = addr >> (int'(cur_cfg.offset_bits) + s);
        found = 1'b0;
        used = 0;
        for (int w = 0; w < nways; w++) begin
            if (!found && line_valid[set_i][w] && line_tag[set_i][w] == tag[TAG_W-1:0]) begin
                found = 1'b1;
                used = w;
            end
        end
        r.hit = found;
        if (found) begin
            if (cur_cfg.policy == POL_LRU)
                promote_way(set_i, nways, used, int'(line_age[set_i][used]));
            if (hits_so_far != '1)
                hits_so_far++;
        end else begin
            for (int w = 0; w < nways; w++) begin
                if (!found && !line_valid[set_i][w]) begin
                    found = 1'b1;
                    used = w;
                end
            end
            if (found) begin
                line_valid[set_i][used] = 1'b1;
                line_tag[set_i][used] = tag[TAG_W-1:0];
                promote_way(set_i, nways, used, int'(RANK_MAX) + 1);
            end else begin
                used = 0;
                for (int w = 1; w < nways; w++) begin
                    if (line_age[set_i][w] > line_age[set_i][used])
                        used = w;
                end
                line_tag[set_i][used] = tag[TAG_W-1:0];
                promote_way(set_i, nways, used, int'(line_age[set_i][used]));
            end
            if (misses_so_far != '1)
                misses_so_far++;
        end
        r.set_idx = set_i[SET_W-1:0];
        r.tag = tag[TAG_W-1:0];
        r.way = used[WAY_W-1:0];
        r.hits = hits_so_far;
        r.misses = misses_so_far;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_access_q.push_back(cache_access(i_address));
                beats_accepted++;
            end
            if (!(start && busy)) begin
                if (pending_addr_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    start <= 1'b1;
                    i_address <= pending_addr_q.pop_front();
                end else begin
                    start <= 1'b0;
                    i_address <= ADDR_W'($urandom);
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        access_t want;
        if (i_rst_n && o_result_valid) begin
            if (expected_access_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result beat with no access pending", $time);
            end else begin
                want = expected_access_q.pop_front();
                if (o_hit !== want.hit || o_set_index !== want.set_idx ||
                    o_tag_value !== want.tag || o_way_used !== want.way ||
                    o_hit_count !== want.hits || o_miss_count !== want.misses) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("%0t: exp hit %0b set %0d tag %h way %0d hits %0d misses %0d, ",
                               $time, want.hit, want.set_idx, want.tag, want.way,
                               want.hits, want.misses);
                        $display("got hit %0b set %0d tag %h way %0d hits %0d misses %0d",
                                 o_hit, o_set_index, o_tag_value, o_way_used, o_hit_count,
                                 o_miss_count);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ADDR_BITS:   cur_cfg.addr_bits = data[4:0];
            CFG_SET_BITS:    cur_cfg.set_bits = data[2:0];
            CFG_WAY_BITS:    cur_cfg.way_bits = data[1:0];
            CFG_OFFSET_BITS: cur_cfg.offset_bits = data[3:0];
            CFG_POLICY:      cur_cfg.policy = t_policy'(data[0]);
            default: ;
        endcase
    endtask

    // unused upper data bits are randomized; a write to an unmapped index goes last
    task automatic apply_config(input logic [4:0] ab, input logic [2:0] sb,
                                input logic [1:0] wb, input logic [3:0] ob,
                                input t_policy pol);
        write_reg(CFG_ADDR_BITS, ab);
        write_reg(CFG_SET_BITS, {2'($urandom), sb});
        write_reg(CFG_WAY_BITS, {3'($urandom), wb});
        write_reg(CFG_OFFSET_BITS, {1'($urandom), ob});
        write_reg(CFG_POLICY, {4'($urandom), pol});
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_POLICY) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_access(input logic [ADDR_W-1:0] a);
        pending_addr_q.push_back(a);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (beats_accepted != items_queued || expected_access_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [ADDR_W-1:0] lru_seq [8] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h000F,
                                           16'h0040, 16'h0000, 16'h0080, 16'h0040};
        logic [ADDR_W-1:0] fifo_seq [5] = '{16'h0010, 16'h0050, 16'h0010, 16'h0090,
                                            16'h0010};
        logic [ADDR_W-1:0] wide_seq [3] = '{16'hFFFF, 16'h8001, 16'hFFFF};
        logic [ADDR_W-1:0] zero_seq [2] = '{16'h1234, 16'hFFFF};
        logic [ADDR_W-1:0] narrow_seq [3] = '{16'hABCD, 16'h0001, 16'h0000};
        int                idle_pcts [3] = '{0, 74, 21};
        logic [ADDR_W-1:0] addr_pool [24];
        logic [7:0]        cluster_lo;
        logic [ADDR_W-1:0] a;
        int                pool_n;
        int                pick;
        int                slot;
        bit                cluster;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill, hit, LRU evictions at reset values
        sender_idle_pct = 21;
        apply_config(5'd16, 3'd2, 2'd1, 4'd4, POL_LRU);
        foreach (lru_seq[i]) queue_access(lru_seq[i]);
        wait_idle();
        // FIFO: a hit must not refresh the way
        apply_config(5'd16, 3'd2, 2'd1, 4'd4, POL_FIFO);
        foreach (fifo_seq[i]) queue_access(fifo_seq[i]);
        wait_idle();
        // address and set bits above their limits, widest ways
        apply_config(5'd31, 3'd7, 2'd3, 4'd0, POL_LRU);
        foreach (wide_seq[i]) queue_access(wide_seq[i]);
        wait_idle();
        // no address bits: every address is zero
        apply_config(5'd0, 3'd2, 2'd1, 4'd4, POL_LRU);
        foreach (zero_seq[i]) queue_access(zero_seq[i]);
        wait_idle();
        // fields wider than the cut address, one way
        apply_config(5'd1, 3'd4, 2'd0, 4'd15, POL_FIFO);
        foreach (narrow_seq[i]) queue_access(narrow_seq[i]);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            sender_idle_pct = idle_pcts[p % 3];
            case (p)
                0: apply_config(5'd16, 3'd4, 2'd3, 4'd0, POL_LRU);
                1: apply_config(5'd16, 3'd4, 2'd3, 4'd0, POL_FIFO);
                2: apply_config(5'd1, 3'd0, 2'd0, 4'd0, POL_LRU);
                3: apply_config(5'd31, 3'd7, 2'd3, 4'd15, POL_FIFO);
                4: apply_config(5'd12, 3'd1, 2'd2, 4'd2, POL_LRU);
                default: apply_config(5'($urandom), 3'($urandom), 2'($urandom),
                                      4'($urandom), t_policy'($urandom_range(1)));
            endcase
            // a small working set, often crowded into one set, so hits and
            // evictions both stay frequent
            pool_n = $urandom_range(1, 24);
            cluster = $urandom_range(1);
            cluster_lo = 8'($urandom);
            for (int k = 0; k < pool_n; k++)
                addr_pool[k] = cluster ? {8'($urandom), cluster_lo} : ADDR_W'($urandom);
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(99);
                slot = $urandom_range(pool_n - 1);
                if (pick < 75) begin
                    a = addr_pool[slot];
                end else if (pick < 90) begin
                    a = ADDR_W'($urandom);
                end else begin
                    a = addr_pool[slot] ^ (ADDR_W'(1) << $urandom_range(ADDR_W - 1));
                    addr_pool[slot] = a;
                end
                queue_access(a);
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_access_q.size() == 0) begin
            $display("tb_set_assoc_cache_hit_miss_top passed");
        end else begin
            $display("tb_set_assoc_cache_hit_miss_top failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_set_assoc_cache_hit_miss_top failed");
        $finish;
    end

endmodule
